>>> rtl/xcfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the XOR-checked frame deframer.
// No dependencies.
package xcfd_pkg;

    localparam logic [7:0] HEADER_RESET = 8'h9a;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CMD   = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_end;
        logic       checksum_ok;
        logic [7:0] payload_length;
    } result_t;

endpackage

>>> rtl/xcfd_in_stage.sv
`timescale 1ns / 1ps
// Input register for received bytes.
// Depends on nothing; feeds xcfd_parser.
module xcfd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;
endmodule

>>> rtl/xcfd_parser.sv
`timescale 1ns / 1ps
// Frame state machine: header hunt, command, length, payload, checksum.
// Uses xcfd_pkg types; sits between xcfd_in_stage and xcfd_out_stage.
module xcfd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        header_byte,
    input  logic              byte_valid,
    input  logic [7:0]        byte_data,
    input  logic              out_room,
    output logic              take,
    output logic              res_valid,
    output xcfd_pkg::result_t res
);
    import xcfd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] seen_reg, seen_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] seen_inc;

    assign take     = byte_valid && out_room;
    assign seen_inc = seen_reg + 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            command_reg <= '0;
            length_reg  <= '0;
            seen_reg    <= '0;
            xor_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            xor_reg     <= xor_next;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        xor_next     = xor_reg;
        res_valid    = 1'b0;
        res.command        = command_reg;
        res.payload_byte   = '0;
        res.payload_index  = '0;
        res.frame_end      = 1'b0;
        res.checksum_ok    = 1'b0;
        res.payload_length = length_reg;
        if (take) begin
            case (phase_reg)
                PH_CMD: begin
                    command_next = byte_data;
                    xor_next     = xor_reg ^ byte_data;
                    phase_next   = PH_LEN;
                end
                PH_LEN: begin
                    length_next = byte_data;
                    xor_next    = xor_reg ^ byte_data;
                    seen_next   = '0;
                    phase_next  = (byte_data == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                    res_valid         = 1'b1;
                    res.payload_byte  = byte_data;
                    res.payload_index = seen_reg;
                    xor_next          = xor_reg ^ byte_data;
                    seen_next         = seen_inc;
                    if (seen_inc == length_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    res_valid       = 1'b1;
                    res.frame_end   = 1'b1;
                    res.checksum_ok = (xor_reg == byte_data);
                    phase_next      = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (byte_data == header_byte) begin
                        xor_next   = byte_data;
                        phase_next = PH_CMD;
                    end
                end
            endcase
        end
    end
endmodule

>>> rtl/xcfd_out_stage.sv
`timescale 1ns / 1ps
// Result register holding one transaction for the m_ channel.
// Uses xcfd_pkg::result_t.
module xcfd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  xcfd_pkg::result_t res,
    output logic              out_room,
    output logic              m_valid,
    input  logic              m_ready,
    output xcfd_pkg::result_t m_res
);
    import xcfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign out_room   = !valid_reg || m_ready;
    assign valid_next = (res_valid && out_room) || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_room) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;
endmodule

>>> rtl/xor_checked_frame_deframer_unit.sv
`timescale 1ns / 1ps
// Deframer for header/command/length/payload/XOR-checksum byte frames.
// Uses xcfd_pkg, xcfd_in_stage, xcfd_parser, xcfd_out_stage.
//
// Accepts one byte per clock unless m_ready stalls the result register,
// and gives at most one transaction per byte: one per payload byte and
// one at the checksum byte (frame_end set). Bytes outside a frame that do
// not match header_byte are dropped, as are header, command and length
// bytes. An accepted byte is registered in the input register, passes the
// single parser and is registered in the result register behind m_valid.
// header_byte resets to 0x9a and is written by cfg_we/cfg_wdata.
module xor_checked_frame_deframer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_command,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_payload_index,
    output logic       m_frame_end,
    output logic       m_checksum_ok,
    output logic [7:0] m_payload_length
);
    import xcfd_pkg::*;

    logic       header_we;
    logic [7:0] header_byte_reg;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       take;
    logic       out_room;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    assign header_we = cfg_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_byte_reg <= HEADER_RESET;
        end else if (header_we) begin
            header_byte_reg <= cfg_wdata;
        end
    end

    xcfd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_in  (s_byte_in),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    xcfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .header_byte (header_byte_reg),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data),
        .out_room    (out_room),
        .take        (take),
        .res_valid   (res_valid),
        .res         (res)
    );

    xcfd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_room  (out_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_command        = m_res.command;
    assign m_payload_byte   = m_res.payload_byte;
    assign m_payload_index  = m_res.payload_index;
    assign m_frame_end      = m_res.frame_end;
    assign m_checksum_ok    = m_res.checksum_ok;
    assign m_payload_length = m_res.payload_length;
endmodule

>>> rtl/xcfd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for xor_checked_frame_deframer_unit, bound to the top.
// No package dependency.
module xcfd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_command,
    input logic [7:0] m_payload_byte,
    input logic [7:0] m_payload_index,
    input logic       m_frame_end,
    input logic       m_checksum_ok,
    input logic [7:0] m_payload_length
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command)
            && $stable(m_payload_byte) && $stable(m_payload_index)
            && $stable(m_frame_end) && $stable(m_checksum_ok))
        else $error("stalled result transaction changed");

    a_ok_only_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_end |-> !m_checksum_ok)
        else $error("checksum_ok set on payload transaction");

    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_payload_byte == 8'd0 && m_payload_index == 8'd0)
        else $error("end transaction carries payload data");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_end |-> m_payload_index < m_payload_length)
        else $error("payload index beyond declared length");
endmodule

bind xor_checked_frame_deframer_unit xcfd_checker u_xcfd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_command        (m_command),
    .m_payload_byte   (m_payload_byte),
    .m_payload_index  (m_payload_index),
    .m_frame_end      (m_frame_end),
    .m_checksum_ok    (m_checksum_ok),
    .m_payload_length (m_payload_length)
);
